/* hw/rtl/gmss_pkg.sv */
// Shared types and constants of the grouped mean and deviation statistics core.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gmss_pkg;

    localparam int MAX_CATEGORIES_DEF = 8;
    localparam int MAX_ITEMS_DEF      = 1024;

    localparam int CAT_W      = 3;
    localparam int PRED_W     = 24;
    localparam int MEAN_W     = 24;
    localparam int SD_W       = 24;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int USED_RESET = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CATEGORIES = 1'b0,
        REG_UNBIASED   = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN1,
        ST_DRAIN1,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_SCAN2,
        ST_DRAIN2,
        ST_ROW,
        ST_VAR_WAIT,
        ST_ROOT_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic store_wr;
        logic scan_clear;
        logic scan_step;
        logic pass2;
        logic cat_clear;
        logic cat_next;
        logic mean_zero;
        logic mean_div;
        logic mean_write;
        logic var_div;
        logic root_start;
        logic out_load;
        logic batch_clear;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic pipe_idle;
        logic div_busy;
        logic root_busy;
        logic cat_empty;
        logic var_skip;
        logic cat_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/gmss_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module gmss_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/gmss_ctrl.sv */
// Controller state machine: sequences loading, both scans, the per-category
// divides and roots, and the emission of result rows. Uses gmss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmss_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              batch_end,
    input  wire gmss_pkg::status_t status,
    output logic                   in_ready,
    output gmss_pkg::cmd_t         cmd
);

    gmss_pkg::state_t state_reg;
    gmss_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmss_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            gmss_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store_wr = 1'b1;
                    if (batch_end)
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = gmss_pkg::ST_SCAN1;
                    end
                end
            end
            gmss_pkg::ST_SCAN1:
            begin
                if (!status.scan_end)
                begin
                    cmd.scan_step = 1'b1;
                end
                else
                begin
                    state_next = gmss_pkg::ST_DRAIN1;
                end
            end
            gmss_pkg::ST_DRAIN1:
            begin
                if (status.pipe_idle)
                begin
                    cmd.cat_clear = 1'b1;
                    state_next    = gmss_pkg::ST_MEAN;
                end
            end
            gmss_pkg::ST_MEAN:
            begin
                if (status.cat_empty)
                begin
                    cmd.mean_zero = 1'b1;
                    if (status.cat_last)
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = gmss_pkg::ST_SCAN2;
                    end
                    else
                    begin
                        cmd.cat_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.mean_div = 1'b1;
                    state_next   = gmss_pkg::ST_MEAN_WAIT;
                end
            end
            gmss_pkg::ST_MEAN_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.mean_write = 1'b1;
                    if (status.cat_last)
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = gmss_pkg::ST_SCAN2;
                    end
                    else
                    begin
                        cmd.cat_next = 1'b1;
                        state_next   = gmss_pkg::ST_MEAN;
                    end
                end
            end
            gmss_pkg::ST_SCAN2:
            begin
                cmd.pass2 = 1'b1;
                if (!status.scan_end)
                begin
                    cmd.scan_step = 1'b1;
                end
                else
                begin
                    state_next = gmss_pkg::ST_DRAIN2;
                end
            end
            gmss_pkg::ST_DRAIN2:
            begin
                if (status.pipe_idle)
                begin
                    cmd.cat_clear = 1'b1;
                    state_next    = gmss_pkg::ST_ROW;
                end
            end
            gmss_pkg::ST_ROW:
            begin
                if (status.var_skip)
                begin
                    state_next = gmss_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.var_div = 1'b1;
                    state_next  = gmss_pkg::ST_VAR_WAIT;
                end
            end
            gmss_pkg::ST_VAR_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.root_start = 1'b1;
                    state_next     = gmss_pkg::ST_ROOT_WAIT;
                end
            end
            gmss_pkg::ST_ROOT_WAIT:
            begin
                if (!status.root_busy)
                begin
                    state_next = gmss_pkg::ST_EMIT;
                end
            end
            gmss_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.cat_last)
                    begin
                        cmd.batch_clear = 1'b1;
                        state_next      = gmss_pkg::ST_LOAD;
                    end
                    else
                    begin
                        cmd.cat_next = 1'b1;
                        state_next   = gmss_pkg::ST_ROW;
                    end
                end
            end
            default:
            begin
                state_next = gmss_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/gmss_dp.sv */
// Datapath: sample store, scan pipeline, per-category accumulators, a shared
// bit-serial divider, a bit-pair square root unit and the result register.
// Uses gmss_pkg and gmss_ram.
`timescale 1ns / 1ps
`default_nettype none

module gmss_dp #(
    parameter int MAX_CATEGORIES = gmss_pkg::MAX_CATEGORIES_DEF,
    parameter int MAX_ITEMS      = gmss_pkg::MAX_ITEMS_DEF,
    localparam int CNT_W         = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [gmss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gmss_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic [gmss_pkg::CAT_W-1:0]          category,
    input  wire logic signed [gmss_pkg::PRED_W-1:0]  prediction,
    input  wire gmss_pkg::cmd_t                      cmd,
    output gmss_pkg::status_t                        status,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [gmss_pkg::CAT_W-1:0]               category_index,
    output logic [CNT_W-1:0]                         sample_count,
    output logic signed [gmss_pkg::MEAN_W-1:0]       mean_value,
    output logic [gmss_pkg::SD_W-1:0]                std_dev,
    output logic                                     degenerate,
    output logic                                     last_row
);

    localparam int PRED_W  = gmss_pkg::PRED_W;
    localparam int CAT_W   = gmss_pkg::CAT_W;
    localparam int MEAN_W  = gmss_pkg::MEAN_W;
    localparam int SD_W    = gmss_pkg::SD_W;
    localparam int ADDR_W  = $clog2(MAX_ITEMS);
    localparam int IDX_W   = $clog2(MAX_CATEGORIES);
    localparam int UW      = $clog2(MAX_CATEGORIES + 1);
    localparam int SUM_W   = PRED_W + ADDR_W;
    localparam int SQ_W    = 2 * PRED_W + ADDR_W;
    localparam int PROD_W  = 2 * PRED_W;
    localparam int DCNT_W  = $clog2(SQ_W + 1);
    localparam int RS      = (SQ_W + 1) / 2;
    localparam int RT_W    = 2 * RS;
    localparam int RCNT_W  = $clog2(RS + 1);
    localparam int ST_W    = CAT_W + PRED_W;
    localparam logic [SD_W-1:0] SD_MAX = '1;

    // Configuration registers.
    logic [gmss_pkg::CFG_W-1:0] cfg_cat_reg;
    logic                       cfg_unb_reg;
    logic [UW-1:0]              used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_cat_reg <= gmss_pkg::CFG_W'(gmss_pkg::USED_RESET);
            cfg_unb_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == gmss_pkg::REG_CATEGORIES)
            begin
                cfg_cat_reg <= cfg_wdata;
            end
            else if (cfg_index == gmss_pkg::REG_UNBIASED)
            begin
                cfg_unb_reg <= cfg_wdata[0];
            end
        end
    end

    always_comb
    begin
        if (cfg_cat_reg == '0)
        begin
            used = UW'(1);
        end
        else if (32'(cfg_cat_reg) > MAX_CATEGORIES)
        begin
            used = UW'(MAX_CATEGORIES);
        end
        else
        begin
            used = UW'(cfg_cat_reg);
        end
    end

    // Sample store and scan address.
    logic [CNT_W-1:0] stored_reg;
    logic [CNT_W-1:0] scan_reg;
    logic             store_full;
    logic [ST_W-1:0]  rd_word;
    logic [CAT_W-1:0] rd_cat;
    logic signed [PRED_W-1:0] rd_pred;

    assign store_full = (stored_reg == CNT_W'(MAX_ITEMS));

    gmss_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.store_wr && !store_full),
        .wr_addr (stored_reg[ADDR_W-1:0]),
        .wr_data ({category, prediction}),
        .rd_en   (cmd.scan_step),
        .rd_addr (scan_reg[ADDR_W-1:0]),
        .rd_data (rd_word)
    );

    assign rd_cat  = rd_word[ST_W-1 -: CAT_W];
    assign rd_pred = $signed(rd_word[PRED_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            if (cmd.batch_clear)
            begin
                stored_reg <= '0;
            end
            else if (cmd.store_wr && !store_full)
            begin
                stored_reg <= stored_reg + CNT_W'(1);
            end
            if (cmd.scan_clear)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + CNT_W'(1);
            end
        end
    end

    // Scan pipeline valid bits.
    logic             v1_reg, p2_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0] cat2_reg, cat3_reg;
    logic [PRED_W-1:0] ad_reg;
    logic [PROD_W-1:0] prod_reg;
    logic             rd_in_range;
    logic [IDX_W-1:0] rd_idx;

    assign rd_in_range = (32'(rd_cat) < 32'(used));
    assign rd_idx      = IDX_W'(rd_cat);

    // Per-category state.
    logic [CNT_W-1:0]         count_reg  [MAX_CATEGORIES];
    logic signed [SUM_W-1:0]  sum_reg    [MAX_CATEGORIES];
    logic [SQ_W-1:0]          sq_reg     [MAX_CATEGORIES];
    logic signed [MEAN_W-1:0] mean_reg   [MAX_CATEGORIES];
    logic [IDX_W-1:0]         cat_reg;

    logic signed [PRED_W:0]   diff;
    logic [PRED_W:0]          diff_abs;
    logic signed [MEAN_W-1:0] rd_mean;

    assign rd_mean  = mean_reg[rd_idx];
    assign diff     = $signed({rd_pred[PRED_W-1], rd_pred}) - $signed({rd_mean[MEAN_W-1], rd_mean});
    assign diff_abs = diff[PRED_W] ? (PRED_W+1)'(-diff) : (PRED_W+1)'(diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            p2_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_step;
            p2_reg <= cmd.pass2;
            v2_reg <= v1_reg && p2_reg && rd_in_range;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cat2_reg <= rd_idx;
        ad_reg   <= diff_abs[PRED_W-1:0];
        cat3_reg <= cat2_reg;
        prod_reg <= ad_reg * ad_reg;
    end

    assign status.pipe_idle = !v1_reg && !v2_reg && !v3_reg;
    assign status.scan_end  = (scan_reg == stored_reg);

    // Shared divider: one quotient bit per cycle.
    logic [SQ_W-1:0]   div_quo_reg;
    logic [CNT_W-1:0]  div_rem_reg;
    logic [CNT_W-1:0]  div_dsr_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic              div_neg_reg;
    logic [CNT_W:0]    div_trial;
    logic              div_ge;
    logic [CNT_W-1:0]  cur_count;
    logic signed [SUM_W-1:0] cur_sum;
    logic [SUM_W-1:0]  sum_mag;
    logic [SQ_W-1:0]   quo_neg;
    logic signed [MEAN_W-1:0] mean_new;

    assign cur_count = count_reg[cat_reg];
    assign cur_sum   = sum_reg[cat_reg];
    assign sum_mag   = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
    assign div_trial = {div_rem_reg, div_quo_reg[SQ_W-1]};
    assign div_ge    = (div_trial >= {1'b0, div_dsr_reg});
    assign quo_neg   = -div_quo_reg;
    assign mean_new  = div_neg_reg ? $signed(quo_neg[MEAN_W-1:0])
                                   : $signed(div_quo_reg[MEAN_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.mean_div || cmd.var_div)
        begin
            div_cnt_reg <= DCNT_W'(SQ_W);
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mean_div)
        begin
            div_quo_reg <= SQ_W'(sum_mag);
            div_rem_reg <= '0;
            div_dsr_reg <= cur_count;
            div_neg_reg <= cur_sum[SUM_W-1];
        end
        else if (cmd.var_div)
        begin
            div_quo_reg <= sq_reg[cat_reg];
            div_rem_reg <= '0;
            div_dsr_reg <= cfg_unb_reg ? cur_count - CNT_W'(1) : cur_count;
            div_neg_reg <= 1'b0;
        end
        else if (div_cnt_reg != '0)
        begin
            div_quo_reg <= {div_quo_reg[SQ_W-2:0], div_ge};
            div_rem_reg <= div_ge ? CNT_W'(div_trial - {1'b0, div_dsr_reg})
                                  : div_trial[CNT_W-1:0];
        end
    end

    assign status.div_busy = (div_cnt_reg != '0);

    // Square root: one result bit per cycle.
    logic [RT_W-1:0]   rt_x_reg, rt_res_reg, rt_bit_reg;
    logic [RCNT_W-1:0] rt_cnt_reg;
    logic [RT_W-1:0]   rt_sum;
    logic              rt_ge;

    assign rt_sum = rt_res_reg + rt_bit_reg;
    assign rt_ge  = (rt_x_reg >= rt_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_cnt_reg <= '0;
        end
        else if (cmd.root_start)
        begin
            rt_cnt_reg <= RCNT_W'(RS);
        end
        else if (rt_cnt_reg != '0)
        begin
            rt_cnt_reg <= rt_cnt_reg - RCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            rt_x_reg   <= RT_W'(div_quo_reg);
            rt_res_reg <= '0;
            rt_bit_reg <= RT_W'(1) << (RT_W - 2);
        end
        else if (rt_cnt_reg != '0)
        begin
            if (rt_ge)
            begin
                rt_x_reg   <= rt_x_reg - rt_sum;
                rt_res_reg <= (rt_res_reg >> 1) + rt_bit_reg;
            end
            else
            begin
                rt_res_reg <= rt_res_reg >> 1;
            end
            rt_bit_reg <= rt_bit_reg >> 2;
        end
    end

    assign status.root_busy = (rt_cnt_reg != '0);

    // Per-category accumulators and category walker.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cat_reg <= '0;
            for (int i = 0; i < MAX_CATEGORIES; i++)
            begin
                count_reg[i] <= '0;
                sum_reg[i]   <= '0;
                sq_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cmd.cat_clear)
            begin
                cat_reg <= '0;
            end
            else if (cmd.cat_next)
            begin
                cat_reg <= cat_reg + IDX_W'(1);
            end
            if (cmd.batch_clear)
            begin
                for (int i = 0; i < MAX_CATEGORIES; i++)
                begin
                    count_reg[i] <= '0;
                    sum_reg[i]   <= '0;
                    sq_reg[i]    <= '0;
                end
            end
            else
            begin
                if (v1_reg && !p2_reg && rd_in_range)
                begin
                    count_reg[rd_idx] <= count_reg[rd_idx] + CNT_W'(1);
                    sum_reg[rd_idx]   <= sum_reg[rd_idx] + SUM_W'(rd_pred);
                end
                if (v3_reg)
                begin
                    sq_reg[cat3_reg] <= sq_reg[cat3_reg] + SQ_W'(prod_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mean_zero)
        begin
            mean_reg[cat_reg] <= '0;
        end
        else if (cmd.mean_write)
        begin
            mean_reg[cat_reg] <= mean_new;
        end
    end

    logic cur_single;
    assign cur_single       = (cur_count == CNT_W'(1));
    assign status.cat_empty = (cur_count == '0);
    assign status.var_skip  = (cur_count == '0) || (cfg_unb_reg && cur_single);
    assign status.cat_last  = (32'(cat_reg) + 1 == 32'(used));

    // Result register.
    logic out_valid_reg;
    logic [SD_W-1:0] sd_sat;

    assign status.out_free = !out_valid_reg || out_ready;
    assign sd_sat = (rt_res_reg > RT_W'(SD_MAX)) ? SD_MAX : rt_res_reg[SD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            category_index <= CAT_W'(cat_reg);
            sample_count   <= cur_count;
            mean_value     <= status.cat_empty ? '0 : mean_reg[cat_reg];
            std_dev        <= status.var_skip ? '0 : sd_sat;
            degenerate     <= cfg_unb_reg && cur_single;
            last_row       <= status.cat_last;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/grouped_mean_stddev_stats_core.sv */
// Rate: items load one per cycle while the core waits for a batch; after the item
// marked batch_end none is accepted until the last row is loaded. The first scan,
// the mean divides (none for an empty category), the second scan and each row's
// divide and root (none without a variance) run in turn, with any wait on the output.
// Each divide runs one quotient bit per cycle and each root one bit per cycle.
// Reset is asynchronous, active low: the store holds no items, accumulators clear.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the grouped statistics core. A batch of items fills the sample
// store; the item that carries batch_end starts two scans of the store. The
// first scan builds a count and a sum per category, after which a shared
// bit-serial divider turns each sum into a mean truncated toward zero. The
// second scan squares each deviation from that mean through a small pipeline
// and accumulates it. Each category row then divides by the count (or count
// minus one in unbiased mode), takes a floor square root and is presented on
// the output register. Items whose category is at or above the number of
// categories in use are ignored, and items beyond the store's depth are dropped.
module grouped_mean_stddev_stats_core #(
    parameter int MAX_CATEGORIES = gmss_pkg::MAX_CATEGORIES_DEF,
    parameter int MAX_ITEMS      = gmss_pkg::MAX_ITEMS_DEF,
    localparam int CNT_W         = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [gmss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gmss_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [gmss_pkg::CAT_W-1:0]          category,
    input  wire logic signed [gmss_pkg::PRED_W-1:0]  prediction,
    input  wire logic                                batch_end,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [gmss_pkg::CAT_W-1:0]               category_index,
    output logic [CNT_W-1:0]                         sample_count,
    output logic signed [gmss_pkg::MEAN_W-1:0]       mean_value,
    output logic [gmss_pkg::SD_W-1:0]                std_dev,
    output logic                                     degenerate,
    output logic                                     last_row
);

    gmss_pkg::cmd_t    cmd;
    gmss_pkg::status_t status;

    // The controller only sequences; all arithmetic and storage sit in the datapath.
    gmss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .batch_end (batch_end),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    gmss_dp #(
        .MAX_CATEGORIES (MAX_CATEGORIES),
        .MAX_ITEMS      (MAX_ITEMS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .category       (category),
        .prediction     (prediction),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .category_index (category_index),
        .sample_count   (sample_count),
        .mean_value     (mean_value),
        .std_dev        (std_dev),
        .degenerate     (degenerate),
        .last_row       (last_row)
    );

endmodule

`default_nettype wire
